@@ src/zoomed_text_character_generator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the zoomed text character generator
// Clocked on clk and disabled while rst_n is low in the including module.
// ----------------------------------------------------------------------------
`ifndef ZOOMED_TEXT_CHARACTER_GENERATOR_ASSERT_SVH
`define ZOOMED_TEXT_CHARACTER_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define ZTCG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ZTCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ztcg_pkg.sv @@
// ----------------------------------------------------------------------------
// ztcg_pkg
// Shared constants, operation codes, read control type and index wrapping.
// ----------------------------------------------------------------------------
package ztcg_pkg;

  localparam int TEXT_CHARS_DEF = 64;
  localparam int FONT_BYTES_DEF = 256;
  localparam int FIRST_GLYPH    = 48;

  localparam int OP_W   = 2;
  localparam int X_W    = 7;
  localparam int Y_W    = 3;
  localparam int CIDX_W = 6;
  localparam int BYTE_W = 8;

  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_CHAR = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE_FONT = 2'd2;
  localparam logic [OP_W-1:0] OP_READ       = 2'd3;

  localparam logic [BYTE_W-1:0] INV_MASK = 8'hff;

  // Wide enough for a biased font address and the modulus shifted by the steps.
  localparam int WRAP_W     = 17;
  localparam int WRAP_STEPS = 6;

  typedef struct packed {
    logic       vld;
    logic       zoom;
    logic [1:0] col;
    logic       hi_nib;
    logic       blank;
    logic       inv;
  } rd_ctl_t;

  // Remainder by restoring subtraction; exact while v < m * 2**WRAP_STEPS.
  function automatic logic [WRAP_W-1:0] wrap_mod(input logic [WRAP_W-1:0] v,
                                                 input logic [WRAP_W-1:0] m);
    logic [WRAP_W-1:0] r;
    r = v;
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return r;
  endfunction

endpackage

@@ src/ztcg_text_store.sv @@
// ----------------------------------------------------------------------------
// ztcg_text_store
// Character memory with per-entry valid flags; one access per transaction.
// ----------------------------------------------------------------------------
module ztcg_text_store #(
  parameter int TEXT_CHARS = ztcg_pkg::TEXT_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [ztcg_pkg::OP_W-1:0]     op,
  input  logic                          zoom_mode,
  input  logic [ztcg_pkg::X_W-1:0]      pixel_x,
  input  logic [ztcg_pkg::Y_W-1:0]      page_y,
  input  logic [ztcg_pkg::CIDX_W-1:0]   char_index,
  input  logic [ztcg_pkg::BYTE_W-1:0]   char_code,
  output logic [ztcg_pkg::BYTE_W-1:0]   chr,
  output ztcg_pkg::rd_ctl_t             ctl
);
  import ztcg_pkg::*;

  localparam int AW = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;

  logic [BYTE_W-1:0]     txt_mem_r [TEXT_CHARS];
  logic [TEXT_CHARS-1:0] vld_r;
  logic [BYTE_W-1:0]     q_r;
  logic                  q_vld_r;
  rd_ctl_t               ctl_r;
  rd_ctl_t               ctl_nxt;
  logic [WRAP_W-1:0]     raw;
  logic [AW-1:0]         addr;

  always_comb begin
    if (op == OP_WRITE_CHAR) begin
      raw = WRAP_W'(char_index);
    end else if (zoom_mode) begin
      raw = WRAP_W'({page_y[2:1], 4'b0000}) + WRAP_W'(pixel_x[6:3]);
    end else begin
      raw = WRAP_W'({page_y, 3'b000}) + WRAP_W'(pixel_x[6:2]);
    end
  end

  assign addr = AW'(wrap_mod(raw, WRAP_W'(TEXT_CHARS)));

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.vld    = acc && (op == OP_READ);
    ctl_nxt.zoom   = zoom_mode;
    ctl_nxt.col    = zoom_mode ? pixel_x[2:1] : pixel_x[1:0];
    ctl_nxt.hi_nib = page_y[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
      if (acc && (op == OP_CLEAR)) begin
        vld_r <= '0;
      end else if (acc && (op == OP_WRITE_CHAR)) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && (op == OP_WRITE_CHAR)) begin
      txt_mem_r[addr] <= char_code;
    end
    q_r     <= txt_mem_r[addr];
    q_vld_r <= vld_r[addr];
  end

  // An entry never written since the last clear reads as a blank.
  assign chr = q_vld_r ? q_r : '0;
  assign ctl = ctl_r;

endmodule

@@ src/ztcg_font_store.sv @@
// ----------------------------------------------------------------------------
// ztcg_font_store
// Font memory: glyph column lookup for reads, byte writes from transactions.
// ----------------------------------------------------------------------------
module ztcg_font_store #(
  parameter int FONT_BYTES = ztcg_pkg::FONT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ztcg_pkg::BYTE_W-1:0]   font_address,
  input  logic [ztcg_pkg::BYTE_W-1:0]   font_byte,
  input  logic [ztcg_pkg::BYTE_W-1:0]   chr,
  input  ztcg_pkg::rd_ctl_t             ctl_in,
  output logic [ztcg_pkg::BYTE_W-1:0]   glyph,
  output ztcg_pkg::rd_ctl_t             ctl_out
);
  import ztcg_pkg::*;

  localparam int AW   = $clog2(FONT_BYTES);
  localparam int BIAS = 3 * FONT_BYTES - 4 * FIRST_GLYPH;

  logic [BYTE_W-1:0] font_mem_r [FONT_BYTES];
  logic [BYTE_W-1:0] q_r;
  rd_ctl_t           ctl_r;
  rd_ctl_t           ctl_nxt;
  logic [BYTE_W-1:0] code7;
  logic [WRAP_W-1:0] rd_raw;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;

  // In zoom mode bit 7 is the inverse flag, not part of the glyph code.
  assign code7   = ctl_in.zoom ? {1'b0, chr[6:0]} : chr;
  assign rd_raw  = WRAP_W'({code7, 2'b00}) + WRAP_W'(ctl_in.col) + WRAP_W'(BIAS);
  assign rd_addr = AW'(wrap_mod(rd_raw, WRAP_W'(FONT_BYTES)));
  assign wr_addr = AW'(wrap_mod(WRAP_W'(font_address), WRAP_W'(FONT_BYTES)));

  always_comb begin
    ctl_nxt       = ctl_in;
    ctl_nxt.blank = (chr == '0);
    ctl_nxt.inv   = ctl_in.zoom && chr[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem_r[wr_addr] <= font_byte;
    end
    q_r <= font_mem_r[rd_addr];
  end

  assign glyph   = q_r;
  assign ctl_out = ctl_r;

endmodule

@@ src/ztcg_pixel_fmt.sv @@
// ----------------------------------------------------------------------------
// ztcg_pixel_fmt
// Output stage: blanking, nibble doubling for zoom, inverse video.
// ----------------------------------------------------------------------------
module ztcg_pixel_fmt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ztcg_pkg::BYTE_W-1:0]   glyph,
  input  ztcg_pkg::rd_ctl_t             ctl,
  output logic                          out_valid,
  output logic [ztcg_pkg::BYTE_W-1:0]   out_column_bits
);
  import ztcg_pkg::*;

  logic [3:0]        nib;
  logic [BYTE_W-1:0] dbl;
  logic [BYTE_W-1:0] bits_nxt;
  logic [BYTE_W-1:0] bits_r;
  logic              valid_r;

  assign nib = ctl.hi_nib ? glyph[7:4] : glyph[3:0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      dbl[2*i]   = nib[i];
      dbl[2*i+1] = nib[i];
    end
  end

  always_comb begin
    if (ctl.blank) begin
      bits_nxt = '0;
    end else if (ctl.zoom) begin
      bits_nxt = ctl.inv ? (dbl ^ INV_MASK) : dbl;
    end else begin
      bits_nxt = glyph;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
  end

  assign out_valid       = valid_r;
  assign out_column_bits = bits_r;

endmodule

@@ src/zoomed_text_character_generator.sv @@
// ----------------------------------------------------------------------------
// zoomed_text_character_generator
// Text-mode character generator with a character memory and a font memory.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy stays low, so a
// transaction is taken at every rising edge where start is high. Clear, write
// character and write font byte finish at the edge that takes them. A read
// column transaction gives its byte on out_column_bits by way of a character
// memory read, a font memory read and the output register, in that order,
// with out_valid high for a single cycle; the receiver cannot hold it off,
// so it must take the byte then. Reads come out in the order they were taken.
// Each memory has one read and one write per cycle, which is what sets the
// rate of one transaction per clock. Clear drops a valid flag per character
// entry, and an entry without its flag reads as blank, so no clearing pass
// runs after reset.
// The font memory holds no reset value; reading a glyph column that was never
// written gives an undefined byte.
module zoomed_text_character_generator #(
  parameter int TEXT_CHARS = ztcg_pkg::TEXT_CHARS_DEF,
  parameter int FONT_BYTES = ztcg_pkg::FONT_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ztcg_pkg::OP_W-1:0]     in_operation,
  input  logic                          in_zoom_mode,
  input  logic [ztcg_pkg::X_W-1:0]      in_pixel_x,
  input  logic [ztcg_pkg::Y_W-1:0]      in_page_y,
  input  logic [ztcg_pkg::CIDX_W-1:0]   in_char_index,
  input  logic [ztcg_pkg::BYTE_W-1:0]   in_char_code,
  input  logic [ztcg_pkg::BYTE_W-1:0]   in_font_address,
  input  logic [ztcg_pkg::BYTE_W-1:0]   in_font_byte,
  output logic                          out_valid,
  output logic [ztcg_pkg::BYTE_W-1:0]   out_column_bits
);
  import ztcg_pkg::*;

`include "zoomed_text_character_generator_assert.svh"

  logic              acc;
  logic              rd_acc;
  logic [BYTE_W-1:0] chr;
  logic [BYTE_W-1:0] glyph;
  rd_ctl_t           ctl_a;
  rd_ctl_t           ctl_b;

  // Every stage moves forward each cycle and writes never wait on reads,
  // so the block is always ready for the next transaction.
  assign busy   = 1'b0;
  assign acc    = start && !busy;
  assign rd_acc = acc && (in_operation == OP_READ);

  // First stage: character lookup, character writes and clear.
  ztcg_text_store #(
    .TEXT_CHARS (TEXT_CHARS)
  ) u_text (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .op         (in_operation),
    .zoom_mode  (in_zoom_mode),
    .pixel_x    (in_pixel_x),
    .page_y     (in_page_y),
    .char_index (in_char_index),
    .char_code  (in_char_code),
    .chr        (chr),
    .ctl        (ctl_a)
  );

  // Second stage: font lookup for the read in flight. A font write taken in
  // the same cycle lands after that lookup, matching transaction order.
  ztcg_font_store #(
    .FONT_BYTES (FONT_BYTES)
  ) u_font (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (acc && (in_operation == OP_WRITE_FONT)),
    .font_address (in_font_address),
    .font_byte    (in_font_byte),
    .chr          (chr),
    .ctl_in       (ctl_a),
    .glyph        (glyph),
    .ctl_out      (ctl_b)
  );

  // Third stage: formatting into the output register.
  ztcg_pixel_fmt u_fmt (
    .clk             (clk),
    .rst_n           (rst_n),
    .glyph           (glyph),
    .ctl             (ctl_b),
    .out_valid       (out_valid),
    .out_column_bits (out_column_bits)
  );

  // A read taken now always comes out with out_valid high.
  `ZTCG_ASSERT_NEXT(a_read_latency, rd_acc, ##2 out_valid, "read result missing")

  // Every result belongs to an earlier read.
  `ZTCG_ASSERT_IMPL(a_no_spurious, out_valid, $past(rd_acc, 3), "spurious result")

  // A blank character always gives an empty column.
  `ZTCG_ASSERT_NEXT(a_blank_zero, ctl_b.vld && ctl_b.blank, out_column_bits == '0, "blank not zero")

endmodule
